FILE: hw/rtl/torque_pid_with_feedforward_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the torque loop controller
// Sampled on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TORQUE_PID_WITH_FEEDFORWARD_TOP_DEFINES_SVH
`define TORQUE_PID_WITH_FEEDFORWARD_TOP_DEFINES_SVH

// ante holds, so cons holds in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// ante holds, so cons holds in the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// ante holds, so cons holds after the delay dly
`define ASSERT_LATER(label, ante, dly, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/tpf_pkg.sv
// ----------------------------------------------------------------------------
// tpf_pkg
// Types, constants and helpers shared by the torque loop controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tpf_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WINDOW_MNM    = 1000;

   localparam int DATA_W   = 32;
   localparam int PERIOD_W = 31;
   localparam int MUL_W    = 33;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FF_GAIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TICK_PERIOD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TICK_RATE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LOAD_OFFSET = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_LOAD_SCALE  = 3'd7;

   localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] prop_gain;
      logic signed [DATA_W-1:0] integ_gain;
      logic signed [DATA_W-1:0] deriv_gain;
      logic signed [DATA_W-1:0] ff_gain;
      logic [PERIOD_W-1:0]      tick_period;
      logic [PERIOD_W-1:0]      tick_rate;
      logic signed [DATA_W-1:0] load_offset;
      logic signed [DATA_W-1:0] load_scale;
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MLOAD,
      ST_LOAD,
      ST_TGT,
      ST_ERR,
      ST_MINT,
      ST_INTG,
      ST_DERV,
      ST_PTERM,
      ST_ITERM,
      ST_DTERM,
      ST_FTERM,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_LOAD,
      MUL_INTEG,
      MUL_DERIV,
      MUL_PROP,
      MUL_IGAIN,
      MUL_DGAIN,
      MUL_FF
   } mul_sel_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        cap_in;
      logic        ld_load;
      logic        ld_tgt;
      logic        ld_err;
      logic        ld_integ;
      logic        ld_deriv;
      logic        acc_first;
      logic        acc_add;
      logic        ld_out;
   } cmd_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] y;
      y = x;
      if (x > SAT_MAX) y = SAT_MAX;
      if (x < SAT_MIN) y = SAT_MIN;
      return y[DATA_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tpf_csr.sv
// ----------------------------------------------------------------------------
// tpf_csr
// Gain, timing and calibration registers behind the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tpf_csr
   import tpf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata,
   output csr_type                   csr
);

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_PROP_GAIN:   csr_in.prop_gain   = csr_wdata;
            REG_INTEG_GAIN:  csr_in.integ_gain  = csr_wdata;
            REG_DERIV_GAIN:  csr_in.deriv_gain  = csr_wdata;
            REG_FF_GAIN:     csr_in.ff_gain     = csr_wdata;
            REG_TICK_PERIOD: csr_in.tick_period = csr_wdata[PERIOD_W-1:0];
            REG_TICK_RATE:   csr_in.tick_rate   = csr_wdata[PERIOD_W-1:0];
            REG_LOAD_OFFSET: csr_in.load_offset = csr_wdata;
            REG_LOAD_SCALE:  csr_in.load_scale  = csr_wdata;
            default:         csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tpf_dpath.sv
// ----------------------------------------------------------------------------
// tpf_dpath
// Datapath: shared 33x33 multiplier, integrator, derivative and sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tpf_dpath
   import tpf_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  csr_type                       csr,
   input  cmd_type                       cmd,
   input  wire logic signed [DATA_W-1:0] cell_voltage,
   input  wire logic signed [DATA_W-1:0] target_torque,
   output logic signed [DATA_W-1:0]      drive_setpoint,
   output logic signed [DATA_W-1:0]      load_torque
);

   localparam longint LIM_RAW = longint'(WINDOW_MNM) << FRAC_BITS;
   localparam longint LIM_L   = (LIM_RAW > 64'sd2147483647) ? 64'sd2147483647 : LIM_RAW;
   localparam logic signed [ACC_W-1:0] LIM   = ACC_W'(LIM_L);
   localparam logic signed [ACC_W-1:0] LIM_N = -LIM;
   localparam logic signed [DATA_W+1:0] LIM_T = (DATA_W+2)'(LIM_L);

   logic signed [DATA_W-1:0] volt_ff, want_ff;
   logic signed [DATA_W-1:0] load_ff, load_in;
   logic signed [DATA_W-1:0] tgt_ff, tgt_in;
   logic signed [DATA_W-1:0] err_ff;
   logic signed [DATA_W-1:0] integ_ff, integ_in;
   logic signed [DATA_W-1:0] last_ff;
   logic signed [DATA_W-1:0] deriv_ff, deriv_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [DATA_W-1:0] drive_ff, drive_in;
   logic signed [DATA_W-1:0] load_out_ff;

   logic signed [MUL_W-1:0]  opa, opb;
   logic signed [ACC_W-1:0]  prod_sh;
   logic signed [ACC_W-1:0]  isum;
   logic signed [DATA_W+1:0] diff, hi, lo, tgt_raw;

   // operand selection for the shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         MUL_LOAD: begin
            opa = MUL_W'(volt_ff) - MUL_W'(csr.load_offset);
            opb = MUL_W'(csr.load_scale);
         end
         MUL_INTEG: begin
            opa = MUL_W'(err_ff);
            opb = $signed({2'b00, csr.tick_period});
         end
         MUL_DERIV: begin
            opa = MUL_W'(err_ff) - MUL_W'(last_ff);
            opb = $signed({2'b00, csr.tick_rate});
         end
         MUL_PROP: begin
            opa = MUL_W'(err_ff);
            opb = MUL_W'(csr.prop_gain);
         end
         MUL_IGAIN: begin
            opa = MUL_W'(integ_ff);
            opb = MUL_W'(csr.integ_gain);
         end
         MUL_DGAIN: begin
            opa = MUL_W'(deriv_ff);
            opb = MUL_W'(csr.deriv_gain);
         end
         MUL_FF: begin
            opa = MUL_W'(tgt_ff);
            opb = MUL_W'(csr.ff_gain);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign prod_in = opa * opb;

   // arithmetic shift gives the floor of the scaled product
   assign prod_sh = ACC_W'(prod_ff) >>> FRAC_BITS;

   // target window around the measured load
   always_comb begin
      diff = (DATA_W+2)'(want_ff) - (DATA_W+2)'(load_ff);
      hi   = (DATA_W+2)'(load_ff) + LIM_T;
      lo   = (DATA_W+2)'(load_ff) - LIM_T;
      if (diff > LIM_T) begin
         tgt_raw = hi;
      end else if (diff < -LIM_T) begin
         tgt_raw = lo;
      end else begin
         tgt_raw = (DATA_W+2)'(want_ff);
      end
   end

   assign load_in  = sat32(prod_sh);
   assign tgt_in   = sat32(ACC_W'(tgt_raw));
   assign deriv_in = sat32(prod_sh);
   assign drive_in = sat32(acc_ff);

   always_comb begin
      isum = ACC_W'(integ_ff) + prod_sh;
      if (isum > LIM) begin
         integ_in = LIM[DATA_W-1:0];
      end else if (isum < LIM_N) begin
         integ_in = LIM_N[DATA_W-1:0];
      end else begin
         integ_in = isum[DATA_W-1:0];
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_first) acc_in = prod_sh;
      if (cmd.acc_add)   acc_in = acc_ff + prod_sh;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (cmd.cap_in) begin
         volt_ff <= cell_voltage;
         want_ff <= target_torque;
      end
      if (cmd.ld_load)  load_ff  <= load_in;
      if (cmd.ld_tgt)   tgt_ff   <= tgt_in;
      if (cmd.ld_err)   err_ff   <= load_ff - tgt_ff;
      if (cmd.ld_deriv) deriv_ff <= deriv_in;
      if (cmd.ld_out) begin
         drive_ff    <= drive_in;
         load_out_ff <= load_ff;
      end
   end

   // loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         last_ff  <= '0;
      end else begin
         if (cmd.ld_integ) integ_ff <= integ_in;
         if (cmd.ld_deriv) last_ff  <= err_ff;
      end
   end

   assign drive_setpoint = drive_ff;
   assign load_torque    = load_out_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tpf_ctrl.sv
// ----------------------------------------------------------------------------
// tpf_ctrl
// Sequencer for one control tick and the result word handshake.
// ----------------------------------------------------------------------------
`default_nettype none

`include "torque_pid_with_feedforward_top_defines.svh"

module tpf_ctrl
   import tpf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   output cmd_type   cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_LOAD;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.cap_in = req_tvalid;
            if (req_tvalid) state_in = ST_MLOAD;
         end
         ST_MLOAD: begin
            cmd.mul_sel = MUL_LOAD;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.ld_load = 1'b1;
            state_in    = ST_TGT;
         end
         ST_TGT: begin
            cmd.ld_tgt = 1'b1;
            state_in   = ST_ERR;
         end
         ST_ERR: begin
            cmd.ld_err = 1'b1;
            state_in   = ST_MINT;
         end
         ST_MINT: begin
            cmd.mul_sel = MUL_INTEG;
            state_in    = ST_INTG;
         end
         ST_INTG: begin
            cmd.ld_integ = 1'b1;
            cmd.mul_sel  = MUL_DERIV;
            state_in     = ST_DERV;
         end
         ST_DERV: begin
            cmd.ld_deriv = 1'b1;
            cmd.mul_sel  = MUL_PROP;
            state_in     = ST_PTERM;
         end
         ST_PTERM: begin
            cmd.acc_first = 1'b1;
            cmd.mul_sel   = MUL_IGAIN;
            state_in      = ST_ITERM;
         end
         ST_ITERM: begin
            cmd.acc_add = 1'b1;
            cmd.mul_sel = MUL_DGAIN;
            state_in    = ST_DTERM;
         end
         ST_DTERM: begin
            cmd.acc_add = 1'b1;
            cmd.mul_sel = MUL_FF;
            state_in    = ST_FTERM;
         end
         ST_FTERM: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            // wait here until the output word is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.ld_out = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.ld_out) rsp_valid_in = 1'b1;
   end

   assign rsp_tvalid = rsp_valid_ff;

   `ASSERT_SAME(a_no_overwrite, cmd.ld_out, !rsp_valid_ff || rsp_tready, "result word overwritten")
   `ASSERT_NEXT(a_one_tick, req_tvalid && req_tready, !req_tready, "second word taken mid tick")
   `ASSERT_LATER(a_sum_start, req_tvalid && req_tready, 8, cmd.acc_first, "sum started off schedule")
   `ASSERT_NEXT(a_out_valid, cmd.ld_out, rsp_valid_ff, "finished word not presented")

endmodule

`default_nettype wire

FILE: hw/rtl/torque_pid_with_feedforward_top.sv
// Torque loop controller, PID with feedforward and integrator clamp. Each
// request word carries a load-cell voltage and a desired torque; each response
// word carries the saturated drive setpoint and the measured load torque, all
// signed fixed point with FRAC_BITS fractional bits. One word is processed at
// a time, since the single 33x33 multiplier is used seven times in turn for
// each tick; a stalled response holds the sequencer in its last step. The
// request side is ready again while the previous response waits. Registers
// are to be written through the csr port only while no tick is in progress;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
// torque_pid_with_feedforward_top
// Top level: register file, sequencer and datapath of the torque loop.
// ----------------------------------------------------------------------------
`default_nettype none

module torque_pid_with_feedforward_top
   import tpf_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [63:0]          req_tdata,   // cell_voltage, target_torque
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [63:0]               rsp_tdata,   // drive_setpoint, load_torque
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata
);

   csr_type                  csr;
   cmd_type                  cmd;
   logic signed [DATA_W-1:0] drive_setpoint;
   logic signed [DATA_W-1:0] load_torque;

   tpf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   tpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   tpf_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr            (csr),
      .cmd            (cmd),
      .cell_voltage   ($signed(req_tdata[31:0])),
      .target_torque  ($signed(req_tdata[63:32])),
      .drive_setpoint (drive_setpoint),
      .load_torque    (load_torque)
   );

   assign rsp_tdata = {load_torque, drive_setpoint};

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the torque loop controller. A clocked driver feeds request words
// from a queue in bursts with random gaps, a clocked monitor takes response
// words under a rotating stall pattern, and a fixed-point model of the PID
// law predicts every response, which is checked field by field in order.
// ----------------------------------------------------------------------------

module tb_top;
   import tpf_pkg::*;

   localparam int     FRAC        = FRAC_BITS_DEF;
   localparam longint WORD_MAX    = 64'sd2147483647;
   localparam longint WORD_MIN    = -64'sd2147483648;
   localparam longint WIN_RAW     = 64'sd1000 << FRAC;
   localparam longint WINDOW      = (WIN_RAW > WORD_MAX) ? WORD_MAX : WIN_RAW;
   localparam int     CYCLE_LIMIT = 300000;
   localparam int     RAND_PHASES = 6;
   localparam int     RAND_ITEMS  = 92;

   // Q16.16 constants used by the directed part
   localparam logic [31:0] Q_ONE     = 32'h0001_0000;
   localparam logic [31:0] Q_HALF    = 32'h0000_8000;
   localparam logic [31:0] Q_100     = 32'h0064_0000;
   localparam logic [31:0] Q_1000    = 32'h03E8_0000;
   localparam logic [31:0] Q_2000    = 32'h07D0_0000;
   localparam logic [31:0] Q_NEG2000 = 32'hF830_0000;
   localparam logic [31:0] Q_5000    = 32'h1388_0000;
   localparam logic [31:0] W_MAX     = 32'h7FFF_FFFF;
   localparam logic [31:0] W_MIN     = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] load_torque;
      logic [31:0] drive_setpoint;
   } tick_result_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [63:0]          req_tdata  = '0;   // cell_voltage, target_torque
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [63:0]          rsp_tdata;         // drive_setpoint, load_torque
   logic                 csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [DATA_W-1:0]    csr_wdata  = '0;

   // controller model: registers and loop state
   longint k_prop = 0, k_integ = 0, k_deriv = 0, k_ff = 0;
   longint t_period = 0, t_rate = 0, cell_offset = 0, cell_scale = 0;
   longint integ_acc = 0, prev_err = 0;

   logic [63:0]     pending_ticks[$];
   tick_result_type awaited_results[$];

   int          fail_count  = 0;
   int          cycle_count = 0;
   int          gap_left    = 0;
   int          burst_left  = 1;
   int          pat_timer   = 0;
   logic [15:0] stall_pat   = 16'hFFFF;

   torque_pid_with_feedforward_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic longint clip_word(input longint x);
      if (x > WORD_MAX) return WORD_MAX;
      if (x < WORD_MIN) return WORD_MIN;
      return x;
   endfunction

   // exact product, then floor shift
   function automatic longint fx_mul(input longint a, input longint b);
      return (a * b) >>> FRAC;
   endfunction

   function automatic tick_result_type predict_tick(input logic [63:0] word);
      longint          volt, want, load, tgt, err, rate_term, total;
      tick_result_type r;
      volt = longint'($signed(word[31:0]));
      want = longint'($signed(word[63:32]));
      load = clip_word(fx_mul(volt - cell_offset, cell_scale));
      tgt = want;
      if (tgt - load > WINDOW)  tgt = load + WINDOW;
      if (tgt - load < -WINDOW) tgt = load - WINDOW;
      tgt = clip_word(tgt);
      err = load - tgt;
      integ_acc = integ_acc + fx_mul(err, t_period);
      if (integ_acc > WINDOW)  integ_acc = WINDOW;
      if (integ_acc < -WINDOW) integ_acc = -WINDOW;
      rate_term = clip_word(fx_mul(err - prev_err, t_rate));
      prev_err = err;
      total = fx_mul(k_prop, err) + fx_mul(k_integ, integ_acc)
            + fx_mul(k_deriv, rate_term) + fx_mul(k_ff, tgt);
      r.drive_setpoint = 32'(clip_word(total));
      r.load_torque    = 32'(load);
      return r;
   endfunction

   function automatic logic [31:0] rand_span(input int unsigned span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   task automatic note_fail(input string what, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s expected %h got %h", $realtime, what, exp_v, act_v);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_PROP_GAIN:   k_prop      = longint'($signed(value));
         REG_INTEG_GAIN:  k_integ     = longint'($signed(value));
         REG_DERIV_GAIN:  k_deriv     = longint'($signed(value));
         REG_FF_GAIN:     k_ff        = longint'($signed(value));
         REG_TICK_PERIOD: t_period    = longint'({1'b0, value[30:0]});
         REG_TICK_RATE:   t_rate      = longint'({1'b0, value[30:0]});
         REG_LOAD_OFFSET: cell_offset = longint'($signed(value));
         REG_LOAD_SCALE:  cell_scale  = longint'($signed(value));
         default: ;
      endcase
   endtask

   task automatic load_regs(input logic [31:0] kp, ki, kd, ff, per, rate, off, scale);
      write_reg(REG_PROP_GAIN,   kp);
      write_reg(REG_INTEG_GAIN,  ki);
      write_reg(REG_DERIV_GAIN,  kd);
      write_reg(REG_FF_GAIN,     ff);
      write_reg(REG_TICK_PERIOD, per);
      write_reg(REG_TICK_RATE,   rate);
      write_reg(REG_LOAD_OFFSET, off);
      write_reg(REG_LOAD_SCALE,  scale);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_tick(input logic [31:0] volt, input logic [31:0] torque);
      pending_ticks.push_back({torque, volt});
   endtask

   // block is idle once every queued word has gone through and come back
   task automatic wait_idle();
      @(negedge clock);
      while (pending_ticks.size() != 0 || req_tvalid || awaited_results.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [31:0] rand_gain();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return rand_span(32'h0004_0000);
   endfunction

   // request driver: bursts of back-to-back words, random gaps in between
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
         burst_left <= 1;
      end else begin
         if (req_tvalid && req_tready)
            awaited_results.push_back(predict_tick(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
               req_tdata  <= {$urandom, $urandom};
            end else if (pending_ticks.size() != 0) begin
               req_tdata  <= pending_ticks.pop_front();
               req_tvalid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(1, 10);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response stall pattern, rotated each cycle and re-picked when its timer runs out
   always @(posedge clock) begin
      if (pat_timer == 0) begin
         pat_timer <= $urandom_range(50, 300);
         case ($urandom_range(0, 3))
            0:       stall_pat <= 16'hFFFF;
            1:       stall_pat <= 16'($urandom) | 16'h0001;
            2:       stall_pat <= 16'h0001;
            default: stall_pat <= 16'($urandom) & 16'($urandom) | 16'h0100;
         endcase
      end else begin
         pat_timer <= pat_timer - 1;
         stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
      rsp_tready <= stall_pat[0];
   end

   // response monitor
   always @(posedge clock) begin
      tick_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            note_fail("unexpected response word", '0, rsp_tdata[31:0]);
         end else begin
            exp_r = awaited_results.pop_front();
            if (rsp_tdata[31:0] !== exp_r.drive_setpoint)
               note_fail("drive_setpoint", exp_r.drive_setpoint, rsp_tdata[31:0]);
            if (rsp_tdata[63:32] !== exp_r.load_torque)
               note_fail("load_torque", exp_r.load_torque, rsp_tdata[63:32]);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // unity calibration, moderate gains, 1 kHz tick
      load_regs(Q_ONE, Q_HALF, 32'h0000_0100, Q_ONE, 32'd66, 32'h03E8_0000,
                32'h0, Q_ONE);
      queue_tick(32'h0, 32'h0);
      queue_tick(Q_100, Q_100);                 // zero error
      queue_tick(Q_100, Q_2000);                // target above window
      queue_tick(Q_100, Q_NEG2000);             // target below window
      queue_tick(W_MAX, W_MIN);
      queue_tick(W_MIN, W_MAX);
      queue_tick(W_MAX, W_MAX);                 // window edge past full scale
      queue_tick(W_MIN, W_MIN);
      queue_tick(32'h1, 32'hFFFF_FFFF);
      repeat (3) queue_tick(32'h0, Q_5000);
      wait_idle();

      // gains, rate and scale at the positive extreme, offset at the negative, period with bit 31 set
      load_regs(W_MAX, W_MAX, W_MAX, W_MAX, 32'hFFFF_FFFF, W_MAX, W_MIN, W_MAX);
      queue_tick(32'h0, Q_1000);
      queue_tick(W_MAX, W_MIN);
      queue_tick(W_MIN, W_MAX);
      queue_tick(32'h0000_3039, 32'hFFFF_CFC7);
      wait_idle();

      // gains, rate and scale at the negative extreme, period and offset at the positive; rate write masks to zero
      load_regs(W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN);
      queue_tick(W_MAX, 32'h0);
      queue_tick(W_MIN, Q_1000);
      queue_tick(32'h0, W_MIN);
      queue_tick(Q_100, Q_NEG2000);
      wait_idle();

      // zero calibration scale and zero cycle time
      load_regs(Q_ONE, Q_ONE, Q_ONE, Q_ONE, 32'h0, 32'h0, $urandom, 32'h0);
      queue_tick(Q_100, Q_2000);
      queue_tick(W_MAX, W_MIN);
      queue_tick(W_MIN, Q_NEG2000);
      queue_tick($urandom, $urandom);
      wait_idle();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         load_regs(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                   ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0001_0000),
                   ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0800_0000),
                   ($urandom_range(0, 4) == 0) ? $urandom : rand_span(32'h0040_0000),
                   ($urandom_range(0, 4) == 0) ? $urandom : rand_span(32'h0002_0000));
         for (int i = 0; i < RAND_ITEMS; i++) begin
            // mostly plausible readings around the calibration point
            if ($urandom_range(0, 99) < 85)
               queue_tick(rand_span(32'h0100_0000), rand_span(32'h0800_0000));
            else
               queue_tick($urandom, $urandom);
         end
         wait_idle();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: torque_pid_with_feedforward_top.f
+incdir+hw/rtl
hw/rtl/tpf_pkg.sv
hw/rtl/tpf_csr.sv
hw/rtl/tpf_dpath.sv
hw/rtl/tpf_ctrl.sv
hw/rtl/torque_pid_with_feedforward_top.sv
bench/tb_top.sv
